FILE: rtl/twn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package twn_pkg;

  localparam int CoordBitsDef = 16;
  localparam int FracBits     = 24;
  localparam int CellW        = 7;
  localparam int NumNbr       = 27;

  localparam logic [CellW-1:0] CellCountRst = 7'd8;
  localparam logic [31:0]      SeedRst      = 32'h0;

  // register indexes
  typedef enum logic [0:0] {
    REG_CELL_COUNT = 1'b0,
    REG_SEED       = 1'b1
  } reg_idx_e;

  // hash constants
  localparam logic [31:0] HashKa = 32'h8da6b343;
  localparam logic [31:0] HashKb = 32'hd8163841;
  localparam logic [31:0] HashKc = 32'hcb1ab31f;
  localparam logic [31:0] HashKs = 32'h9e3779b9;
  localparam logic [31:0] HashKm = 32'h85ebca6b;
  localparam logic [31:0] HyB    = 32'h27d4eb2f;
  localparam logic [31:0] HyC    = 32'h165667b1;
  localparam logic [31:0] HzB    = 32'h85ebca6b;
  localparam logic [31:0] HzC    = 32'hc2b2ae35;

  // constant products of the y and z secondary hashes
  localparam logic [31:0] HyBc = 32'(64'(HyB) * 64'(HashKb)) ^ 32'(64'(HyC) * 64'(HashKc));
  localparam logic [31:0] HzBc = 32'(64'(HzB) * 64'(HashKb)) ^ 32'(64'(HzC) * 64'(HashKc));

  // signed q.24 difference and a sum of three of its squares
  typedef logic signed [FracBits+1:0] diff_t;
  typedef logic [2*FracBits+3:0]       dist_t;

  // wrap one cell index by -1, 0 or +1
  function automatic logic [CellW-1:0] wrap_cell(input logic [CellW:0] idx,
                                                 input logic [1:0] sel,
                                                 input logic [CellW:0] n);
    logic [CellW:0] v;
    v = idx;
    if (sel == 2'd0) begin
      v = (idx == '0) ? n - 1'b1 : idx - 1'b1;
    end else if (sel == 2'd2) begin
      v = (idx + 1'b1 >= n) ? '0 : idx + 1'b1;
    end else begin
      v = (idx >= n) ? '0 : idx;
    end
    return v[CellW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tileable_worley_noise.sv
`timescale 1ns / 1ps
`default_nettype none
// pipeline: 2 front stages, 7 cell-lane stages, 5 min-tree stages, 12 root stages
// and 1 output stage between an accepted beat and its result
// throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place
// reset: valid bits clear, cell_count returns to 8 and seed to 0
module tileable_worley_noise
  import twn_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [0:0]            cfg_idx_i,
  input  wire logic [31:0]           cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [COORD_BITS-1:0] coord_x_i,
  input  wire logic [COORD_BITS-1:0] coord_y_i,
  input  wire logic [COORD_BITS-1:0] coord_z_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 density_o
);

  localparam int Lat   = 27;

  // configuration registers
  logic [CellW-1:0] cell_count_q;
  logic [31:0]      seed_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= CellCountRst;
      seed_q       <= SeedRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CELL_COUNT: cell_count_q <= cfg_wdata_i[CellW-1:0];
        REG_SEED:       seed_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // global advance: whole pipe moves unless the result waits unread
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Lat-1];

  logic [CellW:0] n;
  assign n = (cell_count_q == '0) ? (CellW+1)'(1) : {1'b0, cell_count_q};

  // stage 1: scale coordinates by cell count
  logic [COORD_BITS+CellW:0] cs_q [3];
  logic [CellW:0]            n1_q;
  logic [31:0]               sd1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q[0] <= (COORD_BITS+CellW+1)'(coord_x_i) * (COORD_BITS+CellW+1)'(n);
      cs_q[1] <= (COORD_BITS+CellW+1)'(coord_y_i) * (COORD_BITS+CellW+1)'(n);
      cs_q[2] <= (COORD_BITS+CellW+1)'(coord_z_i) * (COORD_BITS+CellW+1)'(n);
      n1_q    <= n;
      sd1_q   <= seed_q;
    end
  end

  // stage 2: wrapped neighbour indices and fractions
  logic [CellW-1:0]    wi_q [3][3];
  logic [FracBits-1:0] fr_q [3];
  logic [31:0]         sd2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        fr_q[a] <= FracBits'(cs_q[a][COORD_BITS-1:0]) << (FracBits - COORD_BITS);
        for (int d = 0; d < 3; d++) begin
          wi_q[a][d] <= wrap_cell(cs_q[a][COORD_BITS+CellW:COORD_BITS], 2'(d), n1_q);
        end
      end
      sd2_q <= sd1_q;
    end
  end

  // 27 lanes
  dist_t d2 [NumNbr];
  for (genvar k = 0; k < NumNbr; k++) begin : g_lane
    twn_lane #(.DX(k % 3 - 1), .DY((k / 3) % 3 - 1), .DZ(k / 9 - 1)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .cx_i   (wi_q[0][k % 3]),
      .cy_i   (wi_q[1][(k / 3) % 3]),
      .cz_i   (wi_q[2][k / 9]),
      .seed_i (sd2_q),
      .fx_i   (fr_q[0]),
      .fy_i   (fr_q[1]),
      .fz_i   (fr_q[2]),
      .d2_o   (d2[k])
    );
  end

  // registered min tree, 27 -> 9 -> 3 -> 2 -> 1
  dist_t t1_q [9];
  dist_t t2_q [3];
  dist_t t3_q;
  dist_t t2c_q;
  dist_t t4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        t1_q[i] <= (d2[3*i] < d2[3*i+1]) ?
                   ((d2[3*i] < d2[3*i+2]) ? d2[3*i] : d2[3*i+2]) :
                   ((d2[3*i+1] < d2[3*i+2]) ? d2[3*i+1] : d2[3*i+2]);
      end
      for (int i = 0; i < 3; i++) begin
        t2_q[i] <= (t1_q[3*i] < t1_q[3*i+1]) ?
                   ((t1_q[3*i] < t1_q[3*i+2]) ? t1_q[3*i] : t1_q[3*i+2]) :
                   ((t1_q[3*i+1] < t1_q[3*i+2]) ? t1_q[3*i+1] : t1_q[3*i+2]);
      end
      t3_q  <= (t2_q[0] < t2_q[1]) ? t2_q[0] : t2_q[1];
      t2c_q <= t2_q[2];
      t4_q  <= (t3_q < t2c_q) ? t3_q : t2c_q;
    end
  end
  logic [2*FracBits-1:0] best_q;
  logic                  far_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      best_q <= t4_q[2*FracBits-1:0];
      far_q  <= |t4_q[2*FracBits+3:2*FracBits];
    end
  end

  // square root and scaling
  twn_isqrt u_isqrt (
    .clk_i     (clk_i),
    .en_i      (en),
    .far_i     (far_q),
    .val_i     (best_q),
    .density_o (density_o)
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(density_o))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipe stalled with empty output");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid_o))
    else $error("output valid unknown");
`endif

endmodule
`default_nettype wire

FILE: rtl/twn_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// one neighbour cell: hash chain and squared distance, fixed latency
module twn_lane
  import twn_pkg::*;
#(
  parameter int DX = 0,
  parameter int DY = 0,
  parameter int DZ = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [CellW-1:0]      cx_i,
  input  wire logic [CellW-1:0]      cy_i,
  input  wire logic [CellW-1:0]      cz_i,
  input  wire logic [31:0]           seed_i,
  input  wire logic [FracBits-1:0]   fx_i,
  input  wire logic [FracBits-1:0]   fy_i,
  input  wire logic [FracBits-1:0]   fz_i,
  output dist_t                      d2_o
);

  localparam logic signed [FracBits+1:0] OffX = (FracBits+2)'(DX) <<< FracBits;
  localparam logic signed [FracBits+1:0] OffY = (FracBits+2)'(DY) <<< FracBits;
  localparam logic signed [FracBits+1:0] OffZ = (FracBits+2)'(DZ) <<< FracBits;

  typedef struct packed {
    logic [FracBits-1:0] fx;
    logic [FracBits-1:0] fy;
    logic [FracBits-1:0] fz;
  } frac_t;

  // stage a: first mixing products
  logic [31:0] pa_q, pb_q, pc_q, ps_q;
  frac_t       f_a_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= 32'(32'(cx_i) * HashKa);
      pb_q   <= 32'(32'(cy_i) * HashKb);
      pc_q   <= 32'(32'(cz_i) * HashKc);
      ps_q   <= 32'(seed_i * HashKs);
      f_a_q  <= '{fx_i, fy_i, fz_i};
    end
  end

  // stage b: fold, then final multiply of h
  logic [31:0] hx0;
  assign hx0 = pa_q ^ pb_q ^ pc_q ^ ps_q;
  logic [31:0] hm_b_q, ps_b_q;
  frac_t       f_b_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hm_b_q <= 32'((hx0 ^ (hx0 >> 13)) * HashKm);
      ps_b_q <= ps_q;
      f_b_q  <= f_a_q;
    end
  end

  // stage c: h known, multiply for the y and z hashes
  logic [31:0] h_c;
  assign h_c = hm_b_q ^ (hm_b_q >> 16);
  logic [31:0] ph_c_q, ps_c_q;
  logic [15:0] ox_c_q;
  frac_t       f_c_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_c_q <= 32'(h_c * HashKa);
      ox_c_q <= h_c[31:16];
      ps_c_q <= ps_b_q;
      f_c_q  <= f_b_q;
    end
  end

  // stage d: final multiplies of hy and hz
  logic [31:0] y0, z0;
  assign y0 = ph_c_q ^ HyBc ^ ps_c_q;
  assign z0 = ph_c_q ^ HzBc ^ ps_c_q;
  logic [31:0] ym_q, zm_q;
  logic [15:0] ox_d_q;
  frac_t       f_d_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ym_q   <= 32'((y0 ^ (y0 >> 13)) * HashKm);
      zm_q   <= 32'((z0 ^ (z0 >> 13)) * HashKm);
      ox_d_q <= ox_c_q;
      f_d_q  <= f_c_q;
    end
  end

  // stage e: per-axis differences
  logic [31:0] hy, hz;
  assign hy = ym_q ^ (ym_q >> 16);
  assign hz = zm_q ^ (zm_q >> 16);
  diff_t ex_q, ey_q, ez_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q <= OffX + diff_t'({ox_d_q, 8'h0}) - diff_t'(f_d_q.fx);
      ey_q <= OffY + diff_t'({hy[31:16], 8'h0}) - diff_t'(f_d_q.fy);
      ez_q <= OffZ + diff_t'({hz[31:16], 8'h0}) - diff_t'(f_d_q.fz);
    end
  end

  // stage f: squares of the magnitudes, each below 2^50
  logic [FracBits:0] ax, ay, az;
  assign ax = (FracBits+1)'(ex_q[FracBits+1] ? -ex_q : ex_q);
  assign ay = (FracBits+1)'(ey_q[FracBits+1] ? -ey_q : ey_q);
  assign az = (FracBits+1)'(ez_q[FracBits+1] ? -ez_q : ez_q);
  dist_t sx_q, sy_q, sz_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= dist_t'(ax) * dist_t'(ax);
      sy_q <= dist_t'(ay) * dist_t'(ay);
      sz_q <= dist_t'(az) * dist_t'(az);
    end
  end

  // stage g: sum, below 3*2^50 so it fits the distance type
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_o <= sx_q + sy_q + sz_q;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/twn_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// pipelined integer square root, two result bits per stage, then density
module twn_isqrt
  import twn_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic                 far_i,
  input  wire logic [2*FracBits-1:0] val_i,
  output logic [7:0]                density_o
);

  localparam int RootW  = FracBits;
  localparam int Stages = RootW / 2;

  logic [2*FracBits-1:0] rem_q  [Stages+1];
  logic [RootW-1:0]      root_q [Stages+1];
  logic                  far_q  [Stages+1];

  always_comb begin
    rem_q[0]  = val_i;
    root_q[0] = '0;
    far_q[0]  = far_i;
  end

  // restoring square root, one bit per step
  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [2*FracBits-1:0] rem_n;
    logic [RootW-1:0]      root_n;
    always_comb begin
      logic [2*FracBits+1:0] trial;
      int                    b;
      rem_n  = rem_q[s];
      root_n = root_q[s];
      for (int k = 0; k < 2; k++) begin
        b      = RootW - 1 - 2*s - k;
        trial  = ({2'b0, root_n} << (b + 1)) | ((2*FracBits+2)'(1) << (2*b));
        if ({2'b0, rem_n} >= trial) begin
          rem_n  = rem_n - (2*FracBits)'(trial);
          root_n = root_n | (RootW'(1) << b);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_n;
        root_q[s+1] <= root_n;
        far_q[s+1]  <= far_q[s];
      end
    end
  end

  logic [FracBits+8:0] v;
  assign v = (FracBits+9)'(255) * (FracBits+9)'((FracBits+1)'(1) << FracBits) -
             (FracBits+9)'(255) * (FracBits+9)'(root_q[Stages]) +
             (FracBits+9)'((FracBits+1)'(1) << (FracBits-1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      density_o <= far_q[Stages] ? 8'd0 : v[FracBits+7:FracBits];
    end
  end

endmodule
`default_nettype wire
